// ===== design/hslr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hslr_pkg;

  localparam int DIMENSIONS_DEF = 8;
  localparam int ADDR_W         = 8;

  // Safety levels
  localparam logic [1:0] LVL_SAFE   = 2'd0;
  localparam logic [1:0] LVL_UNSAFE = 2'd1;
  localparam logic [1:0] LVL_STRONG = 2'd2;
  localparam logic [1:0] LVL_FAULTY = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_ROUTED  = 3'd0;
  localparam logic [2:0] ST_SELF    = 3'd1;
  localparam logic [2:0] ST_NOROUTE = 3'd2;
  localparam logic [2:0] ST_UPDATED = 3'd3;
  localparam logic [2:0] ST_NOTADJ  = 3'd4;

  // Opcodes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_ROUTE  = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] peer_address;
    logic [1:0]        new_state;
    logic [ADDR_W-1:0] target_address;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] next_dimension;
    logic [1:0] own_state;
    logic       state_changed;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/hypercube_safety_level_router_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Hypercube safety-level router. The core holds one 2-bit safety level per
// hypercube dimension (safe, unsafe, strongly unsafe, faulty) and the node's
// own level. An update transfer reports a neighbour's level: the neighbour
// must differ from own_address in exactly one dimension, otherwise it is
// flagged as not adjacent and nothing changes; the own level is then
// recomputed and a change is flagged. A route transfer names a target and
// returns the next-hop dimension, taken by fixed priority (safe, unsafe,
// then strongly unsafe on differing dimensions, then safe and unsafe on
// agreeing ones) and lowest dimension first within each class. Each item
// is handled by one shared examiner that visits one dimension per cycle:
// the accepting cycle latches the item, the scan state then visits every
// dimension in turn and the resolve state writes the result into the
// output register. A new item is taken only once the previous one has
// been resolved. in_ready is high only while the sequencer is idle; a
// finished result waits in the output register, and the next item may be
// accepted meanwhile. If that next result resolves while the output
// register is still held, the sequencer waits in its resolve state until
// the held result is transferred. own_address is written through
// cfg_wr_en/cfg_wr_data and should only change while the core is idle;
// the neighbour table is kept across such writes.
module hypercube_safety_level_router_core
  import hslr_pkg::*;
#(
  parameter int DIMENSIONS = DIMENSIONS_DEF
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  wire              out_ready,
  output out_item_t        out_data,
  input  wire              cfg_wr_en,
  input  wire [ADDR_W-1:0] cfg_wr_data
);

  localparam int DW    = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;
  localparam int EXT_W = (DIMENSIONS > ADDR_W) ? DIMENSIONS : ADDR_W;
  localparam int NCLS  = 5;

  // Route priority classes, highest first
  localparam int CLS_DIFF_SAFE   = 0;
  localparam int CLS_DIFF_UNSAFE = 1;
  localparam int CLS_DIFF_STRONG = 2;
  localparam int CLS_AGR_SAFE    = 3;
  localparam int CLS_AGR_UNSAFE  = 4;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [DW-1:0]     idx_r, idx_nxt;
  logic [ADDR_W-1:0] own_addr_r;

  // Item being worked on
  logic                  op_r;
  logic [1:0]            new_state_r;
  logic [DIMENSIONS-1:0] diff_r;

  // Scan accumulators
  logic [1:0]    dist_r, dist_nxt;         // differing dimensions, saturating at 3
  logic [DW-1:0] first_diff_r, first_diff_nxt;
  logic          any_safe_r, any_safe_nxt;
  logic [1:0]    faulty_cnt_r, faulty_cnt_nxt;   // saturating at 2
  logic [1:0]    nonsafe_cnt_r, nonsafe_cnt_nxt; // saturating at 3
  logic [NCLS-1:0] found_r, found_nxt;
  logic [DW-1:0]   cls_dim_r [NCLS];
  logic [DW-1:0]   cls_dim_nxt [NCLS];

  logic [1:0] nbr_r [DIMENSIONS];
  logic [1:0] own_lvl_r;

  logic      out_valid_r;
  out_item_t out_data_r, out_data_nxt;

  logic accept_in, load_out, scan_last;
  logic [EXT_W-1:0] own_ext, key_ext;

  // Examiner signals for the dimension under the cursor
  logic       cur_diff;
  logic [1:0] cur_lvl, eff_lvl;
  logic [NCLS-1:0] cur_cls;

  // Resolution
  logic [1:0] lvl_new;
  logic       adjacent, strong_ok;

  assign in_ready  = (state_r == S_IDLE);
  assign accept_in = in_valid && in_ready;
  assign load_out  = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign scan_last = (idx_r == DW'(DIMENSIONS - 1));
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Drop address bits at and above DIMENSIONS
  assign own_ext = EXT_W'(own_addr_r);
  assign key_ext = (in_data.opcode == OP_ROUTE) ? EXT_W'(in_data.target_address)
                                                : EXT_W'(in_data.peer_address);

  // Shared examiner: classify one dimension per cycle
  always_comb begin
    cur_diff = diff_r[idx_r];
    cur_lvl  = nbr_r[idx_r];
    // For the level count, assume the update lands on the differing
    // dimension; the counts are discarded unless exactly one differs.
    eff_lvl  = cur_diff ? new_state_r : cur_lvl;
    cur_cls = '0;
    cur_cls[CLS_DIFF_SAFE]   = cur_diff  && (cur_lvl == LVL_SAFE);
    cur_cls[CLS_DIFF_UNSAFE] = cur_diff  && (cur_lvl == LVL_UNSAFE);
    cur_cls[CLS_DIFF_STRONG] = cur_diff  && (cur_lvl == LVL_STRONG);
    cur_cls[CLS_AGR_SAFE]    = !cur_diff && (cur_lvl == LVL_SAFE);
    cur_cls[CLS_AGR_UNSAFE]  = !cur_diff && (cur_lvl == LVL_UNSAFE);
  end

  // Sequencer and accumulator next values
  always_comb begin
    state_nxt       = state_r;
    idx_nxt         = idx_r;
    dist_nxt        = dist_r;
    first_diff_nxt  = first_diff_r;
    any_safe_nxt    = any_safe_r;
    faulty_cnt_nxt  = faulty_cnt_r;
    nonsafe_cnt_nxt = nonsafe_cnt_r;
    found_nxt       = found_r;
    for (int c = 0; c < NCLS; c++) cls_dim_nxt[c] = cls_dim_r[c];

    unique case (state_r)
      S_IDLE: begin
        if (accept_in) begin
          state_nxt       = S_SCAN;
          idx_nxt         = '0;
          dist_nxt        = '0;
          first_diff_nxt  = '0;
          any_safe_nxt    = 1'b0;
          faulty_cnt_nxt  = '0;
          nonsafe_cnt_nxt = '0;
          found_nxt       = '0;
        end
      end
      S_SCAN: begin
        if (cur_diff && dist_r == 2'd0) first_diff_nxt = idx_r;
        if (cur_diff && dist_r != 2'd3) dist_nxt = dist_r + 2'd1;
        if (eff_lvl == LVL_SAFE) begin
          any_safe_nxt = 1'b1;
        end else begin
          if (nonsafe_cnt_r != 2'd3) nonsafe_cnt_nxt = nonsafe_cnt_r + 2'd1;
          if (eff_lvl == LVL_FAULTY && faulty_cnt_r != 2'd2)
            faulty_cnt_nxt = faulty_cnt_r + 2'd1;
        end
        // Keep the lowest dimension of each class
        for (int c = 0; c < NCLS; c++) begin
          if (cur_cls[c] && !found_r[c]) begin
            found_nxt[c]   = 1'b1;
            cls_dim_nxt[c] = idx_r;
          end
        end
        if (scan_last) state_nxt = S_DONE;
        else           idx_nxt   = idx_r + DW'(1);
      end
      S_DONE: begin
        if (load_out) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Resolve the result from the accumulators
  always_comb begin
    adjacent  = (dist_r == 2'd1);
    strong_ok = (dist_r != 2'd3) || (own_lvl_r == LVL_STRONG);

    if (!any_safe_r)                                lvl_new = LVL_STRONG;
    else if (faulty_cnt_r == 2'd2 || nonsafe_cnt_r == 2'd3) lvl_new = LVL_UNSAFE;
    else                                            lvl_new = LVL_SAFE;

    out_data_nxt = '0;
    out_data_nxt.own_state = own_lvl_r;
    if (op_r == OP_UPDATE) begin
      if (adjacent) begin
        out_data_nxt.status        = ST_UPDATED;
        out_data_nxt.own_state     = lvl_new;
        out_data_nxt.state_changed = (lvl_new != own_lvl_r);
      end else begin
        out_data_nxt.status = ST_NOTADJ;
      end
    end else begin
      priority if (dist_r == 2'd0) begin
        out_data_nxt.status = ST_SELF;
      end else if (found_r[CLS_DIFF_SAFE]) begin
        out_data_nxt.next_dimension = 3'(cls_dim_r[CLS_DIFF_SAFE]);
      end else if (found_r[CLS_DIFF_UNSAFE]) begin
        out_data_nxt.next_dimension = 3'(cls_dim_r[CLS_DIFF_UNSAFE]);
      end else if (found_r[CLS_DIFF_STRONG] && strong_ok) begin
        out_data_nxt.next_dimension = 3'(cls_dim_r[CLS_DIFF_STRONG]);
      end else if (found_r[CLS_AGR_SAFE]) begin
        out_data_nxt.next_dimension = 3'(cls_dim_r[CLS_AGR_SAFE]);
      end else if (found_r[CLS_AGR_UNSAFE]) begin
        out_data_nxt.next_dimension = 3'(cls_dim_r[CLS_AGR_UNSAFE]);
      end else begin
        out_data_nxt.status = ST_NOROUTE;
      end
      if (out_data_nxt.status == ST_ROUTED) begin
        // status left at its default: routed
      end
    end
  end

  // Control state, table and own level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      own_addr_r  <= '0;
      own_lvl_r   <= LVL_STRONG;
      out_valid_r <= 1'b0;
      for (int d = 0; d < DIMENSIONS; d++) nbr_r[d] <= LVL_FAULTY;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (cfg_wr_en) own_addr_r <= cfg_wr_data;
      // Commit an update only as its result is transferred into the output
      if (load_out && op_r == OP_UPDATE && adjacent) begin
        nbr_r[first_diff_r] <= new_state_r;
        own_lvl_r           <= lvl_new;
      end
      if (load_out)       out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  // Payload and accumulator registers
  always_ff @(posedge clk) begin
    if (accept_in) begin
      op_r        <= in_data.opcode;
      new_state_r <= in_data.new_state;
      diff_r      <= own_ext[DIMENSIONS-1:0] ^ key_ext[DIMENSIONS-1:0];
    end
    dist_r        <= dist_nxt;
    first_diff_r  <= first_diff_nxt;
    any_safe_r    <= any_safe_nxt;
    faulty_cnt_r  <= faulty_cnt_nxt;
    nonsafe_cnt_r <= nonsafe_cnt_nxt;
    found_r       <= found_nxt;
    for (int c = 0; c < NCLS; c++) cls_dim_r[c] <= cls_dim_nxt[c];
    if (load_out) out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire
